@@ src/avfr_pkg.sv @@
package avfr_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int MAX_CHANNELS_DEF = 2;

  localparam int VOL_W    = 16;
  localparam int MS_W     = 16;
  localparam int FUNC_W   = 2;
  localparam int CC_W     = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int GAIN_W   = 31;
  localparam int STEP_W   = 32;
  localparam int Q15_SHIFT = 15;
  localparam int FRAC_SHIFT = 30;

  localparam logic [VOL_W-1:0] UNITY_Q15 = 16'd32768;
  localparam logic [CC_W-1:0]  CC_RESET  = 2'd2;

  // step = delta * FADE_NUM / (FADE_DEN * ms), i.e. delta / (22.05 * ms)
  localparam int FADE_NUM = 100;
  localparam int FADE_DEN = 2205;
  localparam int DVD_W    = 37;
  localparam int DVS_W    = 28;
  localparam int DIV_CNT_W = 6;

  localparam logic [FUNC_W-1:0] FUNC_FRAME = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FADE  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_INIT_VOL = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CH_COUNT = 1'd1;

  typedef struct packed {
    logic frame;
    logic set_vol;
    logic fade_now;
    logic fade_load;
    logic div_start;
    logic fade_finish;
  } avfr_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic div_busy;
    logic div_done;
  } avfr_status_t;

  function automatic logic [VOL_W-1:0] clamp_q15(input logic [VOL_W-1:0] v);
    return (v > UNITY_Q15) ? UNITY_Q15 : v;
  endfunction

endpackage

@@ src/avfr_div.sv @@
module avfr_div
  import avfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W:0]       trial;
  logic                 fits;

  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/avfr_dp.sv @@
module avfr_dp
  import avfr_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int IN_DATA_W    = 64,
  parameter int OUT_DATA_W   = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  avfr_cmd_t             cmd,
  output avfr_status_t          status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [VOL_W-1:0]      cfg_wdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int SB      = SAMPLE_BITS;
  localparam int PROD_W  = SB + GAIN_W;
  localparam int LANE0   = 2 * VOL_W;

  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  logic [VOL_W-1:0]         tgt_r, tgt_nxt;
  logic signed [STEP_W-1:0] step_r, step_nxt;
  logic signed [STEP_W-1:0] delta_r, delta_nxt;
  logic [DVS_W-1:0]         dvs_r, dvs_nxt;
  logic [CC_W-1:0]          cc_r, cc_nxt;

  logic                     ovalid_r, ovalid_nxt;
  logic                     olast_r;
  logic [VOL_W-1:0]         ovol_r;
  logic [SB-1:0]            lane_res [MAX_CHANNELS];
  logic [SB-1:0]            lane_r   [MAX_CHANNELS];

  logic [VOL_W-1:0]         vol_in, cfg_vol;
  logic [MS_W-1:0]          ms_in;
  logic [GAIN_W-1:0]        vol_in30;
  logic signed [STEP_W:0]   sum, tgt_ext;
  logic [STEP_W-1:0]        mag;
  logic [DVD_W-1:0]         dvd;
  logic [DVD_W-1:0]         quo;
  logic                     div_busy, div_done;
  logic [STEP_W-1:0]        q_fix;

  assign vol_in   = clamp_q15(in_tdata[VOL_W-1:0]);
  assign ms_in    = in_tdata[VOL_W +: MS_W];
  assign vol_in30 = {vol_in, {Q15_SHIFT{1'b0}}};
  assign cfg_vol  = clamp_q15(cfg_wdata);
  assign sum      = $signed({2'b00, gain_r}) + $signed({step_r[STEP_W-1], step_r});
  assign tgt_ext  = $signed({2'b00, tgt_r, {Q15_SHIFT{1'b0}}});
  assign mag      = delta_r[STEP_W-1] ? STEP_W'(-delta_r) : STEP_W'(delta_r);
  assign dvd      = DVD_W'(mag) * DVD_W'(FADE_NUM);
  assign q_fix    = (quo == '0 && delta_r != '0) ? STEP_W'(1) : quo[STEP_W-1:0];

  avfr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    logic signed [SB-1:0] s;
    logic [SB-1:0]        smag, p;
    logic [PROD_W-1:0]    prod;
    logic                 active;
    assign s      = $signed(in_tdata[LANE0 + i*SB +: SB]);
    assign smag   = s[SB-1] ? SB'(-s) : SB'(s);
    assign prod   = PROD_W'(smag) * PROD_W'(gain_r);
    assign p      = prod[FRAC_SHIFT +: SB];
    assign active = (i == 0) || ({{(32-CC_W){1'b0}}, cc_r} > 32'(i));
    assign lane_res[i] = !active ? '0 : (s[SB-1] ? SB'(-p) : p);
  end

  always_comb begin
    gain_nxt   = gain_r;
    tgt_nxt    = tgt_r;
    step_nxt   = step_r;
    delta_nxt  = delta_r;
    dvs_nxt    = dvs_r;
    cc_nxt     = cc_r;
    ovalid_nxt = ovalid_r && !out_tready;
    if (cmd.frame) begin
      ovalid_nxt = 1'b1;
      if ((step_r > 0 && sum > tgt_ext) || (step_r < 0 && sum < tgt_ext)) begin
        gain_nxt = {tgt_r, {Q15_SHIFT{1'b0}}};
        step_nxt = '0;
      end else begin
        gain_nxt = sum[GAIN_W-1:0];
      end
    end
    if (cmd.set_vol) begin
      gain_nxt = vol_in30;
      step_nxt = '0;
    end
    if (cmd.fade_now) begin
      tgt_nxt  = vol_in;
      gain_nxt = vol_in30;
      step_nxt = '0;
    end
    if (cmd.fade_load) begin
      tgt_nxt   = vol_in;
      delta_nxt = $signed({1'b0, vol_in30}) - $signed({1'b0, gain_r});
      dvs_nxt   = DVS_W'(ms_in) * DVS_W'(FADE_DEN);
    end
    if (cmd.fade_finish) begin
      step_nxt = delta_r[STEP_W-1] ? STEP_W'(-q_fix) : q_fix;
    end
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_INIT_VOL: begin
          if (step_r == '0) begin
            gain_nxt = {cfg_vol, {Q15_SHIFT{1'b0}}};
            tgt_nxt  = cfg_vol;
          end
        end
        CFG_CH_COUNT: cc_nxt = cfg_wdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= {UNITY_Q15, {Q15_SHIFT{1'b0}}};
      tgt_r    <= UNITY_Q15;
      step_r   <= '0;
      cc_r     <= CC_RESET;
      ovalid_r <= 1'b0;
    end else begin
      gain_r   <= gain_nxt;
      tgt_r    <= tgt_nxt;
      step_r   <= step_nxt;
      cc_r     <= cc_nxt;
      ovalid_r <= ovalid_nxt;
    end
    delta_r <= delta_nxt;
    dvs_r   <= dvs_nxt;
    if (cmd.frame) begin
      ovol_r  <= gain_r[Q15_SHIFT +: VOL_W];
      olast_r <= in_tlast;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        lane_r[i] <= lane_res[i];
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      out_tdata[i*SB +: SB] = lane_r[i];
    end
    out_tdata[MAX_CHANNELS*SB +: VOL_W] = ovol_r;
  end

  assign out_tvalid      = ovalid_r;
  assign out_tlast       = olast_r;
  assign status.out_busy = ovalid_r && !out_tready;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;

endmodule

@@ src/avfr_ctrl.sv @@
module avfr_ctrl
  import avfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [FUNC_W-1:0] func,
  input  logic              ms_zero,
  input  avfr_status_t      status,
  output avfr_cmd_t         cmd
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_DIV} state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_tready = (state_r == S_IDLE) && !status.out_busy;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (func)
            FUNC_FRAME: cmd.frame   = 1'b1;
            FUNC_SET:   cmd.set_vol = 1'b1;
            FUNC_FADE: begin
              if (ms_zero) begin
                cmd.fade_now = 1'b1;
              end else begin
                cmd.fade_load = 1'b1;
                state_nxt     = S_START;
              end
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.fade_finish = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/audio_volume_fade_ramp.sv @@
// Linear gain fade ramp for multichannel audio frames.
// Input stream: in_tuser carries the request kind (0 frame, 1 set volume,
// 2 fade), in_tdata the volume, fade length in ms and the channel samples,
// in_tlast the end-of-buffer mark. A frame request yields one result on the
// out_ stream: scaled samples, the gain applied (Q1.15) and tlast copied.
// Set-volume and fade requests yield no result.
// A frame result appears in the cycle after acceptance. Frames and set-volume
// requests are taken one per cycle while the output is not stalled. A fade
// with a nonzero duration occupies the block through load, divider start, the
// bit-serial step divider and finish; in_tready is low meanwhile.
// Reset (rst_n low, synchronous): gain and target at unity, step zero,
// two channels active, output register empty.
// When the receiver stalls, the result is held in the output register and
// in_tready drops until it is taken.
// cfg_we/cfg_addr/cfg_wdata write the start volume (0) or channel_count (1);
// write only while the block is idle.
module audio_volume_fade_ramp
  import avfr_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // volume_value, fade_ms, sample_ch0 .. sample_ch(MAX_CHANNELS-1)
  input  logic [((2*VOL_W + MAX_CHANNELS*SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // func
  input  logic [FUNC_W-1:0]     in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_ch0 .. out_ch(MAX_CHANNELS-1), current_volume
  output logic [((MAX_CHANNELS*SAMPLE_BITS + VOL_W + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [VOL_W-1:0]      cfg_wdata
);

  localparam int IN_DATA_W  = ((2*VOL_W + MAX_CHANNELS*SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((MAX_CHANNELS*SAMPLE_BITS + VOL_W + 7) / 8) * 8;
  localparam int VOL_LSB    = MAX_CHANNELS * SAMPLE_BITS;

  avfr_cmd_t    cmd;
  avfr_status_t status;
  logic         ms_zero;

  assign ms_zero = in_tdata[VOL_W +: MS_W] == '0;

  avfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .func      (in_tuser),
    .ms_zero   (ms_zero),
    .status    (status),
    .cmd       (cmd)
  );

  avfr_dp #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .IN_DATA_W    (IN_DATA_W),
    .OUT_DATA_W   (OUT_DATA_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_busy |-> !in_tready)
    else $error("request accepted while step divider busy");

  a_fade_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == FUNC_FADE && !ms_zero) |=> !in_tready)
    else $error("fade request did not hold off input");

  a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == FUNC_FRAME) |=> out_tvalid)
    else $error("frame request gave no result");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[VOL_LSB +: VOL_W] <= UNITY_Q15)
    else $error("reported gain above unity");

endmodule

@@ test/avfr_result_checker.sv @@
`timescale 1ns / 100ps

module avfr_result_checker
  import avfr_pkg::*;
#(
  parameter int IN_W  = 64,
  parameter int OUT_W = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic [FUNC_W-1:0]     in_tuser,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_W-1:0]      out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [VOL_W-1:0]      cfg_wdata,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic signed [15:0] ch0;
    logic signed [15:0] ch1;
    logic [VOL_W-1:0]   vol;
    logic               last;
  } scaled_frame_t;

  scaled_frame_t frames_due[$];

  // gain model
  logic [GAIN_W-1:0]        gain;
  logic [VOL_W-1:0]         gain_tgt;
  logic signed [STEP_W-1:0] step;
  logic [CC_W-1:0]          ch_count;

  function automatic logic [VOL_W-1:0] sat_unity(input logic [VOL_W-1:0] v);
    return (v > UNITY_Q15) ? UNITY_Q15 : v;
  endfunction

  // sample * gain, magnitude truncated, sign restored
  function automatic logic signed [15:0] apply_gain(input logic signed [15:0] s,
                                                    input logic [GAIN_W-1:0] g);
    longint mag;
    longint prod;
    mag  = (s < 0) ? -longint'(s) : longint'(s);
    prod = (mag * longint'(g)) >>> FRAC_SHIFT;
    return (s < 0) ? 16'(-prod) : 16'(prod);
  endfunction

  task automatic write_register();
    logic [VOL_W-1:0] vol;
    if (cfg_addr == CFG_INIT_VOL) begin
      vol = sat_unity(cfg_wdata);
      if (step == 0) begin
        gain     = {vol, {Q15_SHIFT{1'b0}}};
        gain_tgt = vol;
      end
    end else if (cfg_addr == CFG_CH_COUNT) begin
      ch_count = cfg_wdata[CC_W-1:0];
    end
  endtask

  task automatic predict_request();
    logic [FUNC_W-1:0]  op;
    logic [VOL_W-1:0]   vol;
    logic [MS_W-1:0]    ms;
    logic signed [15:0] s0;
    logic signed [15:0] s1;
    longint             tgt30;
    longint             delta;
    longint             mag;
    longint             quo;
    longint             nxt;
    scaled_frame_t      r;
    op  = in_tuser;
    vol = sat_unity(in_tdata[15:0]);
    ms  = in_tdata[31:16];
    s0  = in_tdata[47:32];
    s1  = in_tdata[63:48];
    case (op)
      FUNC_SET: begin
        gain = {vol, {Q15_SHIFT{1'b0}}};
        step = '0;
      end
      FUNC_FADE: begin
        gain_tgt = vol;
        tgt30    = longint'(vol) << Q15_SHIFT;
        if (ms == 0) begin
          gain = GAIN_W'(tgt30);
          step = '0;
        end else begin
          delta = tgt30 - longint'(gain);
          mag   = (delta < 0) ? -delta : delta;
          quo   = (mag * FADE_NUM) / (FADE_DEN * longint'(ms));
          if (quo == 0 && mag != 0) quo = 1;
          step = (delta < 0) ? STEP_W'(-quo) : STEP_W'(quo);
        end
      end
      FUNC_FRAME: begin
        r.ch0  = apply_gain(s0, gain);
        r.ch1  = (ch_count >= 2) ? apply_gain(s1, gain) : 16'sd0;
        r.vol  = gain[GAIN_W-1:Q15_SHIFT];
        r.last = in_tlast;
        frames_due.push_back(r);
        nxt   = longint'(gain) + longint'(step);
        tgt30 = longint'(gain_tgt) << Q15_SHIFT;
        if ((step > 0 && nxt > tgt30) || (step < 0 && nxt < tgt30)) begin
          nxt  = tgt30;
          step = '0;
        end
        gain = GAIN_W'(nxt);
      end
      default: ;
    endcase
  endtask

  task automatic compare_result();
    scaled_frame_t exp_r;
    logic signed [15:0] got0;
    logic signed [15:0] got1;
    logic [VOL_W-1:0]   gotv;
    got0 = out_tdata[15:0];
    got1 = out_tdata[31:16];
    gotv = out_tdata[47:32];
    if (frames_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unrequested result ch0=%0d ch1=%0d vol=%0d last=%0b",
                 $realtime, got0, got1, gotv, out_tlast);
    end else begin
      exp_r = frames_due.pop_front();
      if (got0 !== exp_r.ch0 || got1 !== exp_r.ch1 || gotv !== exp_r.vol ||
          out_tlast !== exp_r.last) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp ch0=%0d ch1=%0d vol=%0d last=%0b",
                   $realtime, exp_r.ch0, exp_r.ch1, exp_r.vol, exp_r.last);
          $display("%0t:          got ch0=%0d ch1=%0d vol=%0d last=%0b",
                   $realtime, got0, got1, gotv, out_tlast);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      errors   = 0;
      gain     = {UNITY_Q15, {Q15_SHIFT{1'b0}}};
      gain_tgt = UNITY_Q15;
      step     = '0;
      ch_count = CC_RESET;
      frames_due.delete();
    end else begin
      // a result always belongs to a request accepted on an earlier edge
      if (out_tvalid && out_tready) compare_result();
      if (cfg_we) write_register();
      if (in_tvalid && in_tready) predict_request();
    end
    pending <= frames_due.size();
  end

endmodule

@@ test/tb_audio_volume_fade_ramp.sv @@
`timescale 1ns / 100ps

module tb_audio_volume_fade_ramp;
  import avfr_pkg::*;

  localparam int IN_W  = ((2*VOL_W + MAX_CHANNELS_DEF*SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((MAX_CHANNELS_DEF*SAMPLE_BITS_DEF + VOL_W + 7) / 8) * 8;
  localparam int LIMIT       = 400000;
  localparam int SETTLE      = 50;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASES      = 8;
  localparam int PHASE_REQS  = 45;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;   // volume_value, fade_ms, sample_ch0, sample_ch1
  logic [FUNC_W-1:0]     in_tuser;   // func
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // out_ch0, out_ch1, current_volume
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [VOL_W-1:0]      cfg_wdata;

  int err_count;
  int frames_outstanding;
  int cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  bit holding = 1'b0;

  logic [15:0] vol_set [PHASES] = '{16'h0000, UNITY_Q15, 16'hFFFF, 16'd1,
                                    16'h7FFF, 16'h8001, 16'h0000, 16'h4000};
  logic [15:0] cc_set  [PHASES] = '{16'd1, 16'd2, 16'd0, 16'd3,
                                    16'hFFFD, 16'd1, 16'd2, 16'hFFFE};

  always #5 clk = ~clk;

  audio_volume_fade_ramp u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  avfr_result_checker #(
    .IN_W (IN_W),
    .OUT_W(OUT_W)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .errors    (err_count),
    .pending   (frames_outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[audio_volume_fade_ramp] ERROR");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            out_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
          end
          4, 5, 6: begin
            out_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
          end
          7: begin
            out_tready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge clk);
          end
          default: begin
            out_tready <= 1'b1;
            @(posedge clk);
          end
        endcase
      end
    end
  end

  function automatic int pick_gap();
    case ($urandom_range(0, 19))
      10, 11, 12, 13, 14, 15, 16: return $urandom_range(1, 3);
      17, 18:                     return $urandom_range(4, 12);
      19:                         return $urandom_range(20, 60);
      default:                    return 0;
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] op, input logic [15:0] vol,
                              input logic [15:0] ms, input logic [15:0] s0,
                              input logic [15:0] s1, input logic last);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {s1, s0, ms, vol};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_frame(input logic [15:0] s0, input logic [15:0] s1, input logic last);
    send_request(FUNC_FRAME, 16'($urandom), 16'($urandom), s0, s1, last);
  endtask

  task automatic send_random();
    logic [15:0] vol;
    logic [15:0] ms;
    int pick;
    case ($urandom_range(0, 9))
      0:       vol = 16'h0000;
      1:       vol = UNITY_Q15;
      2:       vol = 16'($urandom);
      default: vol = 16'($urandom_range(0, 32768));
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 2)       ms = 16'd0;
    else if (pick < 12) ms = 16'($urandom_range(1, 2));
    else if (pick < 17) ms = 16'($urandom_range(3, 30));
    else                ms = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70)
      send_frame(pick_sample(), pick_sample(), 1'($urandom));
    else if (pick < 80)
      send_request(FUNC_SET, vol, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    else if (pick < 94)
      send_request(FUNC_FADE, vol, ms, 16'($urandom), 16'($urandom), 1'($urandom));
    else
      send_request(FUNC_SPARE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom));
  endtask

  // sender stops until all frame results are back, then lets a fade finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] vol, input logic [15:0] cc);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_INIT_VOL;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_addr  <= CFG_CH_COUNT;
    cfg_wdata <= cc;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    send_frame(16'h8000, 16'h7FFF, 1'b1);
    send_frame(16'h7FFF, 16'hFFFF, 1'b0);
    send_request(FUNC_SET, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 1'b1);
    send_frame(16'h8001, 16'd12345, 1'b0);
    send_request(FUNC_SET, 16'd16384, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_frame(16'h8001, 16'hFFFF, 1'b1);
    // ramp up toward unity (about 22 frames), cut short by the next fade after three frames
    send_request(FUNC_FADE, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 1'b1);
    repeat (3) send_frame(pick_sample(), pick_sample(), 1'b0);
    send_request(FUNC_FADE, 16'd20000, 16'd0, 16'h1234, 16'h5678, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b1);
    send_request(FUNC_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(FUNC_SET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    // step too small for the divider: one unit per frame upward
    send_request(FUNC_FADE, 16'd1, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    repeat (2) send_frame(16'h8000, 16'h7FFF, 1'b0);
    // one unit per frame down to zero: lands exactly, then overshoot snap
    send_request(FUNC_FADE, 16'h0000, 16'd1, 16'h0000, 16'h0000, 1'b0);
    repeat (3) send_frame(16'h8000, 16'h7FFF, 1'b1);
    send_request(FUNC_FADE, 16'd30000, 16'd100, 16'h0000, 16'h0000, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_FRAME;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_INIT_VOL;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      // initial volume writes land both mid-ramp and with the ramp stopped
      write_config(ph >= 5 ? 16'($urandom_range(0, 32768)) : vol_set[ph], cc_set[ph]);
      no_gaps = (ph % 3 == 1);
      if (ph == 2) begin
        hold_req = 1'b1;
        while (!holding) @(posedge clk);
        no_gaps = 1'b1;
        repeat (12) send_frame(pick_sample(), pick_sample(), 1'($urandom));
        no_gaps = 1'b0;
      end
      repeat (PHASE_REQS) send_random();
      wait_idle();
    end

    if (err_count == 0 && frames_outstanding == 0) begin
      $display("[audio_volume_fade_ramp] OK");
    end else begin
      $display("[audio_volume_fade_ramp] ERROR");
    end
    $finish;
  end

endmodule
